@@ sv/task_table_priority_scheduler_defines.svh @@
// assertion macros used by the scheduler datapath rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef TASK_TABLE_PRIORITY_SCHEDULER_DEFINES_SVH
`define TASK_TABLE_PRIORITY_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TTPS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define TTPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ttps_pkg.sv @@
// shared types and constants of the task table priority scheduler
// no dependencies
`default_nettype none

package ttps_pkg;

	// operation codes of the input transaction
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_SELECT = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	localparam int PRIO_W = 14;
	localparam int WAIT_W = 16;
	localparam int MASK_W = 16;
	localparam int ID_W   = 4;

	// slot index widened to cover the largest table
	localparam int SLOT_EXT_W = 7;
	localparam logic [SLOT_EXT_W-1:0] MASK_SLOTS = 7'd16;

	localparam logic [PRIO_W-1:0] CEILING_RESET = 14'd10000;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic clear;
		logic walk;
		logic flush;
	} ttps_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic walk_done;
		logic flush_ok;
	} ttps_sts_t;

endpackage

`default_nettype wire

@@ sv/task_table_priority_scheduler.sv @@
// task table scheduler: insert, select, tick and clear over MAX_TASKS slots.
// clear takes effect in the accept cycle; insert and select deliver their result
// after the walk; tick results come during the walk, the last one in the flush state.
// one operation at a time; the walk goes one slot per cycle unless a tick expiry
// stalls it, through the single read port of the slot memories; clear needs no walk.
// reset: all slots invalid, ceiling 10000; slot memories need no clearing pass.
`default_nettype none

module task_table_priority_scheduler #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [ttps_pkg::PRIO_W-1:0] cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  op,
	input  wire logic [ttps_pkg::MASK_W-1:0] task_mask,
	input  wire logic [ttps_pkg::PRIO_W-1:0] new_priority,
	input  wire logic [ttps_pkg::WAIT_W-1:0] new_wait_ticks,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [ttps_pkg::ID_W-1:0]        task_id,
	output logic                             found,
	output logic                             last
);
	import ttps_pkg::*;

	ttps_cmd_t cmd;
	ttps_sts_t sts;
	op_t       op_code;

	assign op_code = op_t'(op);

	// sequencing
	ttps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op_code),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// table and result datapath
	ttps_dp #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.op             (op_code),
		.task_mask      (task_mask),
		.new_priority   (new_priority),
		.new_wait_ticks (new_wait_ticks),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.task_id        (task_id),
		.found          (found),
		.last           (last)
	);

endmodule

`default_nettype wire

@@ sv/ttps_ctrl.sv @@
// controller state machine of the scheduler: accept, walk the table, deliver
// depends on ttps_pkg
`default_nettype none

module ttps_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire ttps_pkg::op_t    op,
	output logic                  in_ready,
	output ttps_pkg::ttps_cmd_t   cmd,
	input  wire ttps_pkg::ttps_sts_t sts
);
	import ttps_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WALK  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	// one operation at a time
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (op != OP_CLEAR)) state_d = S_WALK;
			end
			S_WALK: begin
				if (sts.walk_done) state_d = S_FLUSH;
			end
			S_FLUSH: begin
				if (sts.flush_ok) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// commands
	always_comb begin
		cmd.load  = accept && (op != OP_CLEAR);
		cmd.clear = accept && (op == OP_CLEAR);
		cmd.walk  = (state_q == S_WALK);
		cmd.flush = (state_q == S_FLUSH);
	end

endmodule

`default_nettype wire

@@ sv/ttps_dp.sv @@
// datapath of the scheduler: slot memories, valid flags, walk counter,
// selection, tick countdown and the output register; depends on ttps_pkg and the defines header
`default_nettype none

`include "task_table_priority_scheduler_defines.svh"

module ttps_dp #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ttps_pkg::ttps_cmd_t          cmd,
	output ttps_pkg::ttps_sts_t               sts,
	input  wire logic                         cfg_wr_en,
	input  wire logic [ttps_pkg::PRIO_W-1:0]  cfg_wr_data,
	input  wire ttps_pkg::op_t                op,
	input  wire logic [ttps_pkg::MASK_W-1:0]  task_mask,
	input  wire logic [ttps_pkg::PRIO_W-1:0]  new_priority,
	input  wire logic [ttps_pkg::WAIT_W-1:0]  new_wait_ticks,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [ttps_pkg::ID_W-1:0]         task_id,
	output logic                              found,
	output logic                              last
);
	import ttps_pkg::*;

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] END_CNT = CNT_W'(MAX_TASKS);

	// slot storage
	logic [PRIO_W-1:0] prio_mem [MAX_TASKS];
	logic [WAIT_W-1:0] wait_mem [MAX_TASKS];
	logic [MAX_TASKS-1:0] valid_q;

	// operation context
	op_t               op_q;
	logic [MASK_W-1:0] mask_q;
	logic [PRIO_W-1:0] new_prio_q;
	logic [WAIT_W-1:0] new_wait_q;
	logic [PRIO_W-1:0] ceiling_q;

	// walk: issue counter and evaluation stage
	logic [CNT_W-1:0]  a_q;
	logic              ev_v_s1;
	logic [IDX_W-1:0]  ev_idx_s1;
	logic [PRIO_W-1:0] rd_prio_s1;
	logic [WAIT_W-1:0] rd_wait_s1;

	// running results
	logic [PRIO_W-1:0] best_q;
	logic [ID_W-1:0]   best_id_q;
	logic              any_q;
	logic              hold_v_q;
	logic [ID_W-1:0]   hold_id_q;

	// output register
	logic            out_valid_q;
	logic [ID_W-1:0] out_id_q;
	logic            out_found_q;
	logic            out_last_q;

	logic [SLOT_EXT_W-1:0] ev_ext;
	logic [ID_W-1:0]       ev_id;
	logic                  ev_slot_valid, in_mask, elig;
	logic                  is_tick, is_insert, is_select;
	logic                  tick_dec, expire, out_room, stall, adv, issue;
	logic                  ins_write, sel_win, tick_push, flush_push, push;
	logic                  wait_wr_en;
	logic [WAIT_W-1:0]     wait_wr_data;
	logic [ID_W-1:0]       push_id;
	logic                  push_found, push_last;

	// slot under evaluation
	assign ev_ext        = SLOT_EXT_W'(ev_idx_s1);
	assign ev_id         = ev_ext[ID_W-1:0];
	assign ev_slot_valid = valid_q[ev_idx_s1];
	assign in_mask       = (ev_ext < MASK_SLOTS) && mask_q[ev_ext[ID_W-1:0]];
	assign elig          = ev_slot_valid && in_mask;

	assign is_tick   = (op_q == OP_TICK);
	assign is_insert = (op_q == OP_INSERT);
	assign is_select = (op_q == OP_SELECT);

	// walk control; only a second expiry against a full output stalls it
	assign tick_dec = ev_v_s1 && is_tick && elig && (rd_wait_s1 != '0);
	assign expire   = tick_dec && (rd_wait_s1 == WAIT_W'(1));
	assign out_room = !out_valid_q || out_ready;
	assign stall    = cmd.walk && expire && hold_v_q && !out_room;
	assign adv      = cmd.walk && !stall;
	assign issue    = adv && (a_q < END_CNT);

	// per-slot decisions
	assign ins_write = adv && ev_v_s1 && is_insert && !ev_slot_valid && !any_q;
	assign sel_win   = adv && ev_v_s1 && is_select && elig && (rd_prio_s1 < best_q);

	assign wait_wr_en   = ins_write || (adv && tick_dec);
	assign wait_wr_data = ins_write ? new_wait_q : (rd_wait_s1 - WAIT_W'(1));

	// result pushes into the output register
	assign tick_push  = adv && expire && hold_v_q;
	assign flush_push = cmd.flush && out_room && (!is_tick || hold_v_q);
	assign push       = tick_push || flush_push;

	always_comb begin
		if (tick_push) begin
			push_id    = hold_id_q;
			push_found = 1'b1;
			push_last  = 1'b0;
		end else if (is_tick) begin
			push_id    = hold_id_q;
			push_found = 1'b1;
			push_last  = 1'b1;
		end else begin
			push_id    = best_id_q;
			push_found = any_q;
			push_last  = 1'b1;
		end
	end

	// status
	always_comb begin
		sts.walk_done = (a_q == END_CNT) && !ev_v_s1;
		sts.flush_ok  = out_room || (is_tick && !hold_v_q);
	end

	// memories: registered read at the issue address, write at the evaluated slot
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_prio_s1 <= prio_mem[a_q[IDX_W-1:0]];
		end
		if (ins_write) begin
			prio_mem[ev_idx_s1] <= new_prio_q;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_wait_s1 <= wait_mem[a_q[IDX_W-1:0]];
		end
		if (wait_wr_en) begin
			wait_mem[ev_idx_s1] <= wait_wr_data;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			ceiling_q   <= CEILING_RESET;
			a_q         <= '0;
			ev_v_s1     <= 1'b0;
			any_q       <= 1'b0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				ceiling_q <= cfg_wr_data;
			end
			if (cmd.clear) begin
				valid_q <= '0;
			end else if (ins_write) begin
				valid_q[ev_idx_s1] <= 1'b1;
			end
			// walk counter and stage valid
			if (cmd.load) begin
				a_q     <= '0;
				ev_v_s1 <= 1'b0;
			end else if (adv) begin
				ev_v_s1 <= issue;
				if (issue) a_q <= a_q + CNT_W'(1);
			end
			// found flag of insert and select
			if (cmd.load) begin
				any_q <= 1'b0;
			end else if (ins_write || sel_win) begin
				any_q <= 1'b1;
			end
			// expired slot held back until its successor or the end is known
			if (cmd.load) begin
				hold_v_q <= 1'b0;
			end else if (adv && expire) begin
				hold_v_q <= 1'b1;
			end else if (flush_push) begin
				hold_v_q <= 1'b0;
			end
			// output register
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= op;
			mask_q     <= task_mask;
			new_prio_q <= new_priority;
			new_wait_q <= new_wait_ticks;
			best_q     <= ceiling_q;
			best_id_q  <= '0;
		end else if (ins_write) begin
			best_id_q <= ev_id;
		end else if (sel_win) begin
			best_q    <= rd_prio_s1;
			best_id_q <= ev_id;
		end
		if (issue) begin
			ev_idx_s1 <= a_q[IDX_W-1:0];
		end
		if (adv && expire) begin
			hold_id_q <= ev_id;
		end
		if (push) begin
			out_id_q    <= push_id;
			out_found_q <= push_found;
			out_last_q  <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign task_id   = out_id_q;
	assign found     = out_found_q;
	assign last      = out_last_q;

	// checks
	`TTPS_ASSERT_IMPL(a_push_room, push, out_room, "result pushed into a full output register")
	`TTPS_ASSERT_IMPL(a_hold_tick, hold_v_q, is_tick, "held result outside a tick")
	`TTPS_ASSERT_IMPL(a_ev_behind, ev_v_s1 && cmd.walk, (CNT_W'(ev_idx_s1) + CNT_W'(1)) == a_q,
		"evaluated slot out of step with the issue counter")
	`TTPS_ASSERT_NEXT(a_stall_freeze, stall, ev_v_s1 && $stable(ev_idx_s1),
		"evaluation stage moved during a stall")

endmodule

`default_nettype wire
